[rtl/core/mm4x4_pkg.sv]
package mm4x4_pkg;

  localparam int LANES    = 4;
  localparam int ELEM_W   = 32;
  localparam int ROW_W    = 2;
  localparam int PROD_W   = 2 * ELEM_W;
  localparam int PAIR_W   = PROD_W + 1;
  localparam int SUM_W    = PROD_W + 2;
  localparam int FIELDS_W = ROW_W + LANES * ELEM_W;
  localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;

  localparam int DIM_DEF       = 4;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_MUL  = 1'b1
  } cmd_t;

  typedef logic signed [ELEM_W-1:0] elem_t;

endpackage

[rtl/core/matrix_multiply_4x4.sv]
// Channel | Beat                                       | Handshake
// in_     | tuser: command; tdata: row_index, elem_0..3 | in_tvalid / in_tready
// out_    | tuser: saturated; tdata: out_row, prod_0..3 | out_tvalid / out_tready
//
// One beat per cycle while the output is not stalled; a multiply row passes four stages
// (multiply, pair add, final add, shift and saturate) before it is valid on the output.
// A load beat writes the stored right-matrix row at acceptance and yields no result.
// Reset clears the stage valid bits only; stored rows stay unknown until loaded.
// Each stage advances while the stage after it is empty or advancing, so a
// waiting result stalls only the stages behind it that are full.
module matrix_multiply_4x4 #(
  parameter int DIM       = mm4x4_pkg::DIM_DEF,
  parameter int FRAC_BITS = mm4x4_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [mm4x4_pkg::TDATA_W-1:0] in_tdata,   // row_index, elem_0, elem_1, elem_2, elem_3
  input  logic                          in_tuser,   // command
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mm4x4_pkg::TDATA_W-1:0] out_tdata,  // out_row, prod_0, prod_1, prod_2, prod_3
  output logic                          out_tuser   // saturated
);
  import mm4x4_pkg::*;

  localparam int ACT = (DIM < LANES) ? DIM : LANES;

  logic signed [ELEM_W-1:0] right_r [ACT][ACT];

  elem_t                    elem [LANES];
  logic [ROW_W-1:0]         row_in;
  logic                     accept;
  logic                     is_load;
  logic                     row_ok;

  logic signed [PROD_W-1:0] prod_nxt [LANES][LANES];
  logic signed [PROD_W-1:0] prod_r   [LANES][LANES];
  logic signed [PAIR_W-1:0] pair_nxt [LANES][2];
  logic signed [PAIR_W-1:0] pair_r   [LANES][2];
  logic signed [SUM_W-1:0]  sum_nxt  [LANES];
  logic signed [SUM_W-1:0]  sum_r    [LANES];
  elem_t                    res_nxt  [LANES];
  logic [LANES-1:0]         clip_nxt;
  elem_t                    res_r    [LANES];
  logic                     sat_r;

  logic [ROW_W-1:0]         row1_r, row2_r, row3_r, row4_r;
  logic                     v1_r, v2_r, v3_r, v4_r;
  logic                     rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_r || out_tready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_tready = rdy1;
  assign accept    = in_tvalid && rdy1;
  assign is_load   = (cmd_t'(in_tuser) == CMD_LOAD);
  assign row_in    = in_tdata[ROW_W-1:0];
  assign row_ok    = int'(row_in) < ACT;

  for (genvar k = 0; k < LANES; k++) begin : g_elem
    assign elem[k] = in_tdata[ROW_W + ELEM_W*k +: ELEM_W];
  end

  // right-matrix store, written at acceptance of a load beat
  for (genvar r = 0; r < ACT; r++) begin : g_wr_row
    for (genvar c = 0; c < ACT; c++) begin : g_wr_col
      always_ff @(posedge clk) begin
        if (accept && is_load && row_in == ROW_W'(r)) begin
          right_r[r][c] <= elem[c];
        end
      end
    end
  end

  // stage 1: products
  for (genvar x = 0; x < LANES; x++) begin : g_px
    for (genvar k = 0; k < LANES; k++) begin : g_pk
      if (x < ACT && k < ACT) begin : g_live
        assign prod_nxt[x][k] = row_ok ? elem[k] * right_r[k][x] : PROD_W'(0);
      end else begin : g_zero
        assign prod_nxt[x][k] = '0;
      end
    end
  end

  // stages 2 to 4: pair sums, full sums, shift and saturate
  always_comb begin
    for (int x = 0; x < LANES; x++) begin
      pair_nxt[x][0] = PAIR_W'(prod_r[x][0]) + PAIR_W'(prod_r[x][1]);
      pair_nxt[x][1] = PAIR_W'(prod_r[x][2]) + PAIR_W'(prod_r[x][3]);
      sum_nxt[x]     = SUM_W'(pair_r[x][0]) + SUM_W'(pair_r[x][1]);
    end
  end

  for (genvar x = 0; x < LANES; x++) begin : g_sat
    logic signed [SUM_W-1:0] shifted;
    assign shifted = sum_r[x] >>> FRAC_BITS;
    always_comb begin
      clip_nxt[x] = !((&shifted[SUM_W-1:ELEM_W-1]) || !(|shifted[SUM_W-1:ELEM_W-1]));
      if (clip_nxt[x]) begin
        res_nxt[x] = shifted[SUM_W-1] ? {1'b1, {(ELEM_W-1){1'b0}}}
                                      : {1'b0, {(ELEM_W-1){1'b1}}};
      end else begin
        res_nxt[x] = shifted[ELEM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_tvalid && !is_load;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_load) begin
      prod_r <= prod_nxt;
      row1_r <= row_in;
    end
    if (rdy2 && v1_r) begin
      pair_r <= pair_nxt;
      row2_r <= row1_r;
    end
    if (rdy3 && v2_r) begin
      sum_r  <= sum_nxt;
      row3_r <= row2_r;
    end
    if (rdy4 && v3_r) begin
      res_r  <= res_nxt;
      sat_r  <= |clip_nxt;
      row4_r <= row3_r;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tuser  = sat_r;
  assign out_tdata  = {(TDATA_W - FIELDS_W)'(0), res_r[3], res_r[2], res_r[1], res_r[0], row4_r};

`ifndef ASSERT_OFF
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_load |=> !v1_r)
    else $error("load beat entered the pipeline");

  a_mul_enters: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_load |=> v1_r)
    else $error("multiply beat lost at entry");

  a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !rdy2 |=> v1_r && $stable(row1_r))
    else $error("stalled stage 1 changed");

  a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      res_r[0] == {1'b1, {(ELEM_W-1){1'b0}}} || res_r[0] == {1'b0, {(ELEM_W-1){1'b1}}} ||
      res_r[1] == {1'b1, {(ELEM_W-1){1'b0}}} || res_r[1] == {1'b0, {(ELEM_W-1){1'b1}}} ||
      res_r[2] == {1'b1, {(ELEM_W-1){1'b0}}} || res_r[2] == {1'b0, {(ELEM_W-1){1'b1}}} ||
      res_r[3] == {1'b1, {(ELEM_W-1){1'b0}}} || res_r[3] == {1'b0, {(ELEM_W-1){1'b1}}})
    else $error("saturation flag without a clipped element");

  a_row_beyond: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && int'(row4_r) >= ACT |-> !out_tuser && res_r[0] == '0)
    else $error("row beyond matrix gave a nonzero result");
`endif

endmodule
